// ===== sv/mahsd_pkg.sv =====
// Shared types, codes and rate tables for the MPEG audio header sync decoder.
`timescale 1ns / 1ps

package mahsd_pkg;

    typedef enum logic [2:0] {
        STATUS_OK          = 3'd0,
        STATUS_NO_SYNC     = 3'd1,
        STATUS_BAD_VERSION = 3'd2,
        STATUS_BAD_BITRATE = 3'd3,
        STATUS_BAD_FREQ    = 3'd4
    } status_t;

    localparam logic [11:0] COUNT_MAX   = 12'd4095;
    localparam logic [7:0]  SYNC_BYTE   = 8'hff;
    localparam logic [2:0]  SYNC_TOP    = 3'b111;
    localparam logic [1:0]  VER_MPEG1   = 2'd3;
    localparam logic [1:0]  VER_MPEG2   = 2'd2;
    localparam logic [1:0]  VER_RESERVED = 2'd1;
    localparam logic [1:0]  LAYER_I     = 2'd3;
    localparam logic [1:0]  LAYER_II    = 2'd2;
    localparam logic [1:0]  LAYER_RESERVED = 2'd0;
    localparam logic [3:0]  RATE_FREE   = 4'd0;
    localparam logic [3:0]  RATE_BAD    = 4'd15;
    localparam logic [1:0]  FREQ_RESERVED = 2'd3;
    localparam logic [10:0] SAMPLES_LAYER_I = 11'd384;
    localparam logic [10:0] SAMPLES_OTHER   = 11'd1152;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUOT_BITS   = 12;
    localparam int NUM_BITS    = 26;

    // bitrate in bit/s by index and column
    // columns: V1 L1, V1 L2, V1 L3, V2/2.5 L1, V2/2.5 L2/L3
    localparam logic [18:0] RATE_TABLE [16][5] = '{
        '{19'd0,      19'd0,      19'd0,      19'd0,      19'd0},
        '{19'd32000,  19'd32000,  19'd32000,  19'd32000,  19'd8000},
        '{19'd64000,  19'd48000,  19'd40000,  19'd48000,  19'd16000},
        '{19'd96000,  19'd56000,  19'd48000,  19'd56000,  19'd24000},
        '{19'd128000, 19'd64000,  19'd56000,  19'd64000,  19'd32000},
        '{19'd160000, 19'd80000,  19'd64000,  19'd80000,  19'd40000},
        '{19'd192000, 19'd96000,  19'd80000,  19'd96000,  19'd48000},
        '{19'd224000, 19'd112000, 19'd96000,  19'd112000, 19'd56000},
        '{19'd256000, 19'd128000, 19'd112000, 19'd128000, 19'd64000},
        '{19'd288000, 19'd160000, 19'd128000, 19'd144000, 19'd80000},
        '{19'd320000, 19'd192000, 19'd160000, 19'd160000, 19'd96000},
        '{19'd352000, 19'd224000, 19'd192000, 19'd176000, 19'd112000},
        '{19'd384000, 19'd256000, 19'd224000, 19'd192000, 19'd128000},
        '{19'd416000, 19'd320000, 19'd256000, 19'd224000, 19'd144000},
        '{19'd448000, 19'd384000, 19'd320000, 19'd256000, 19'd160000},
        '{19'd0,      19'd0,      19'd0,      19'd0,      19'd0}
    };

    // sample rate in Hz by index and version column (MPEG1, MPEG2, MPEG2.5)
    localparam logic [15:0] FREQ_TABLE [3][3] = '{
        '{16'd44100, 16'd22050, 16'd11025},
        '{16'd48000, 16'd24000, 16'd12000},
        '{16'd32000, 16'd16000, 16'd8000}
    };

    typedef struct packed {
        status_t     status;
        logic [11:0] offset;
        logic [1:0]  version;
        logic [1:0]  layer;
        logic        padded;
        logic [3:0]  rate_idx;
        logic [1:0]  freq_idx;
    } entry_t;

    typedef struct packed {
        status_t     status;
        logic [11:0] offset;
        logic [1:0]  version;
        logic [1:0]  layer;
        logic        padded;
        logic [18:0] rate_bps;
        logic [15:0] freq_hz;
        logic [10:0] samples;
        logic [11:0] frame_bytes;
    } result_t;

endpackage

// ===== sv/mahsd_front.sv =====
// Byte scanner: finds the frame sync in a packet and classifies the header.
`timescale 1ns / 1ps

module mahsd_front #(
    parameter int MAX_PAYLOAD_BYTES = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_payload_byte,
    input  logic               s_packet_end,
    input  logic               q_ready,
    output logic               q_push,
    output mahsd_pkg::entry_t  q_data
);
    import mahsd_pkg::*;

    logic [23:0] recent_reg, recent_next;
    logic [11:0] seen_reg, seen_next;
    logic        reported_reg, reported_next;
    logic        accept;
    logic        hit;
    logic [7:0]  h1;
    logic [7:0]  h2;
    entry_t      hdr;

    assign s_ready = q_ready;
    assign accept  = s_valid && s_ready;
    assign h1      = recent_reg[15:8];
    assign h2      = recent_reg[7:0];

    assign hit = !reported_reg && (seen_reg >= 12'd3)
               && ({20'd0, seen_reg} < 32'(MAX_PAYLOAD_BYTES))
               && (recent_reg[23:16] == SYNC_BYTE) && (h1[7:5] == SYNC_TOP);

    always_comb begin
        hdr          = '0;
        hdr.offset   = (seen_reg == COUNT_MAX) ? COUNT_MAX : seen_reg - 12'd3;
        hdr.version  = h1[4:3];
        hdr.layer    = h1[2:1];
        hdr.padded   = h2[1];
        hdr.rate_idx = h2[7:4];
        hdr.freq_idx = h2[3:2];
        if (hdr.version == VER_RESERVED || hdr.layer == LAYER_RESERVED) begin
            hdr.status = STATUS_BAD_VERSION;
        end else if (hdr.rate_idx == RATE_FREE || hdr.rate_idx == RATE_BAD) begin
            hdr.status = STATUS_BAD_BITRATE;
        end else if (hdr.freq_idx == FREQ_RESERVED) begin
            hdr.status = STATUS_BAD_FREQ;
        end else begin
            hdr.status = STATUS_OK;
        end
    end

    always_comb begin
        q_push = accept && (hit || (s_packet_end && !reported_reg));
        if (hit) begin
            q_data = hdr;
        end else begin
            q_data        = '0;
            q_data.status = STATUS_NO_SYNC;
        end
    end

    always_comb begin
        recent_next   = recent_reg;
        seen_next     = seen_reg;
        reported_next = reported_reg;
        if (accept) begin
            if (s_packet_end) begin
                recent_next   = '0;
                seen_next     = '0;
                reported_next = 1'b0;
            end else begin
                recent_next   = {recent_reg[15:0], s_payload_byte};
                seen_next     = (seen_reg == COUNT_MAX) ? seen_reg : seen_reg + 12'd1;
                reported_next = reported_reg || hit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recent_reg   <= '0;
            seen_reg     <= '0;
            reported_reg <= 1'b0;
        end else begin
            recent_reg   <= recent_next;
            seen_reg     <= seen_next;
            reported_reg <= reported_next;
        end
    end

endmodule

// ===== sv/mahsd_queue.sv =====
// Short queue of classified headers between the scanner and the decoder.
`timescale 1ns / 1ps

module mahsd_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  mahsd_pkg::entry_t  wr_data,
    output logic               wr_ready,
    input  logic               pop,
    output logic               rd_valid,
    output mahsd_pkg::entry_t  rd_data
);
    import mahsd_pkg::*;

    entry_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign wr_ready = (count_reg != QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign do_push  = push && wr_ready;
    assign do_pop   = pop && rd_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (QUEUE_AW+1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== sv/mahsd_back.sv =====
// Header decoder: rate lookup, bit-serial frame length divide, result register.
`timescale 1ns / 1ps

module mahsd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  mahsd_pkg::entry_t   q_data,
    output logic                q_pop,
    output logic                res_valid,
    input  logic                res_ready,
    output mahsd_pkg::result_t  res
);
    import mahsd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CALC = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    entry_t                 job_reg;
    logic [18:0]            br_reg;
    logic [15:0]            sr_reg;
    logic [15:0]            rem_reg;
    logic [QUOT_BITS-1:0]   low_reg;
    logic [QUOT_BITS-1:0]   quo_reg;
    logic [3:0]             step_reg, step_next;
    logic                   valid_reg, valid_next;
    result_t                res_reg;

    logic [2:0]             col;
    logic [1:0]             fcol;
    logic [18:0]            br;
    logic [15:0]            sr;
    logic [NUM_BITS-1:0]    num;
    logic [16:0]            trial;
    logic                   fits;
    logic [QUOT_BITS-1:0]   len_sum;
    logic [11:0]            len;
    logic                   out_free;
    logic                   load_out;
    result_t                res_new;

    assign out_free  = !valid_reg || res_ready;
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign load_out  = (state_reg == S_DONE) && out_free;
    assign res_valid = valid_reg;
    assign res       = res_reg;

    always_comb begin
        if (job_reg.version == VER_MPEG1) begin
            col = (job_reg.layer == LAYER_I) ? 3'd0 : (job_reg.layer == LAYER_II) ? 3'd1 : 3'd2;
            fcol = 2'd0;
        end else begin
            col  = (job_reg.layer == LAYER_I) ? 3'd3 : 3'd4;
            fcol = (job_reg.version == VER_MPEG2) ? 2'd1 : 2'd2;
        end
        br = RATE_TABLE[job_reg.rate_idx][col];
        sr = FREQ_TABLE[job_reg.freq_idx][fcol];
        if (job_reg.layer == LAYER_I) begin
            num = NUM_BITS'({br, 3'b000}) + NUM_BITS'({br, 2'b00});
        end else begin
            num = NUM_BITS'({br, 7'b0000000}) + NUM_BITS'({br, 4'b0000});
        end
    end

    assign trial = {rem_reg, low_reg[QUOT_BITS-1]};
    assign fits  = (trial >= {1'b0, sr_reg});

    always_comb begin
        len_sum = quo_reg + QUOT_BITS'(job_reg.padded);
        len     = (job_reg.layer == LAYER_I) ? {len_sum[9:0], 2'b00} : len_sum;
        res_new         = '0;
        res_new.status  = job_reg.status;
        res_new.offset  = job_reg.offset;
        res_new.version = job_reg.version;
        res_new.layer   = job_reg.layer;
        res_new.padded  = job_reg.padded;
        if (job_reg.status == STATUS_NO_SYNC) begin
            res_new         = '0;
            res_new.status  = STATUS_NO_SYNC;
        end else if (job_reg.status == STATUS_OK) begin
            res_new.rate_bps    = br_reg;
            res_new.freq_hz     = sr_reg;
            res_new.samples     = (job_reg.layer == LAYER_I) ? SAMPLES_LAYER_I : SAMPLES_OTHER;
            res_new.frame_bytes = len;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        valid_next = valid_reg;
        if (valid_reg && res_ready) begin
            valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    state_next = (q_data.status == STATUS_OK) ? S_CALC : S_DONE;
                end
            end
            S_CALC: begin
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                step_next = step_reg + 4'd1;
                if (step_reg == 4'(QUOT_BITS - 1)) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_data;
        end
        if (state_reg == S_CALC) begin
            br_reg  <= br;
            sr_reg  <= sr;
            rem_reg <= {2'b00, num[NUM_BITS-1:QUOT_BITS]};
            low_reg <= num[QUOT_BITS-1:0];
            quo_reg <= '0;
        end else if (state_reg == S_DIV) begin
            rem_reg <= fits ? 16'(trial - {1'b0, sr_reg}) : trial[15:0];
            low_reg <= {low_reg[QUOT_BITS-2:0], 1'b0};
            quo_reg <= {quo_reg[QUOT_BITS-2:0], fits};
        end
        if (load_out) begin
            res_reg <= res_new;
        end
    end

endmodule

// ===== sv/mpeg_audio_header_sync_decoder.sv =====
// MPEG audio frame header sync and decode, top level.
// Throughput: one payload byte per cycle while the header queue has room.
// A valid header passes the queue, the rate lookup, the bit-serial frame
// length divider and the result register; errors and no-sync results skip
// the lookup and the divider. Synchronous active-low reset clears the
// scanner, the queue and the result valid.
`timescale 1ns / 1ps

module mpeg_audio_header_sync_decoder #(
    parameter int MAX_PAYLOAD_BYTES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_payload_byte,
    input  logic        s_packet_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [11:0] m_header_offset,
    output logic [1:0]  m_version_code,
    output logic [1:0]  m_layer_code,
    output logic        m_padded,
    output logic [18:0] m_bit_rate_bps,
    output logic [15:0] m_sample_rate_hz,
    output logic [10:0] m_samples_per_frame,
    output logic [11:0] m_frame_bytes
);
    import mahsd_pkg::*;

    logic    q_push;
    logic    q_ready;
    entry_t  q_wr_data;
    logic    q_pop;
    logic    q_valid;
    entry_t  q_rd_data;
    result_t res;

    mahsd_front #(
        .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload_byte (s_payload_byte),
        .s_packet_end   (s_packet_end),
        .q_ready        (q_ready),
        .q_push         (q_push),
        .q_data         (q_wr_data)
    );

    mahsd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_data  (q_wr_data),
        .wr_ready (q_ready),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_rd_data)
    );

    mahsd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_data    (q_rd_data),
        .q_pop     (q_pop),
        .res_valid (m_valid),
        .res_ready (m_ready),
        .res       (res)
    );

    assign m_status            = res.status;
    assign m_header_offset     = res.offset;
    assign m_version_code      = res.version;
    assign m_layer_code        = res.layer;
    assign m_padded            = res.padded;
    assign m_bit_rate_bps      = res.rate_bps;
    assign m_sample_rate_hz    = res.freq_hz;
    assign m_samples_per_frame = res.samples;
    assign m_frame_bytes       = res.frame_bytes;

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> q_ready)
        else $error("header queue overflow");

    a_ok_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STATUS_OK) |->
        (m_frame_bytes != 12'd0 && m_sample_rate_hz != 16'd0 && m_bit_rate_bps != 19'd0))
        else $error("ok result with empty fields");

    a_nosync_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STATUS_NO_SYNC) |->
        (m_header_offset == 12'd0 && m_bit_rate_bps == 19'd0 && m_frame_bytes == 12'd0))
        else $error("no-sync result with nonzero fields");

    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("decoder popped an empty queue");

endmodule
